FILE: src/assert_macros.svh
// Assertion macros for the motion-triggered LED chase RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define MTLC_ASSERT(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition in one cycle that implies another condition in the next cycle.
`define MTLC_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/mtlc_pkg.sv
// Package with the types, codes and constants of the motion-triggered LED chase.
`timescale 1ns / 1ps
package mtlc_pkg;

	// Defaults for the top-level parameters.
	localparam int LED_COUNT_DEF       = 3;
	localparam int BURST_PER_LEVEL_DEF = 10;

	// Configuration register indexes and reset values.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF   = 1'd1;
	localparam logic [15:0] THRESHOLD_RESET = 16'd500;
	localparam logic [15:0] HOLDOFF_RESET   = 16'd15;

	// Wake request codes.
	localparam logic [1:0] WAKE_KEEP = 2'd0;
	localparam logic [1:0] WAKE_FAST = 2'd1;
	localparam logic [1:0] WAKE_SLOW = 2'd2;

	// Running average: keep 99/100 of the old value.
	// The divide by 100 is a shift by two and a multiply by the reciprocal of 25.
	localparam int          AVG_SUM_W = 23;
	localparam logic [22:0] AVG_KEEP  = 23'd99;
	localparam logic [21:0] RECIP_25  = 22'd2684355;
	localparam int          RECIP_SH  = 26;

	// One input transaction.
	typedef struct packed {
		logic [7:0]  sample;
		logic [15:0] tick_period;
	} tick_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0] motion_level;
		logic       pulse_valid;
		logic [1:0] pulse_led;
		logic [1:0] wake_request;
	} result_t;

endpackage

FILE: src/mtlc_detect.sv
// Running average of the samples and motion level detection.
`timescale 1ns / 1ps
module mtlc_detect (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd,
	input  logic [7:0]  sample,
	input  logic [15:0] motion_threshold,
	output logic [1:0]  level
);
	import mtlc_pkg::*;

	logic [15:0]          average_q;
	logic [15:0]          val;
	logic [AVG_SUM_W-1:0] avg_sum;
	logic [20:0]          quarter;
	logic [42:0]          prod;
	logic [15:0]          avg;
	logic [15:0]          diff;
	logic                 motion;
	logic [16:0]          thr2;
	logic [17:0]          thr3;

	// New average: floor((average * 99 + sample * 256) / 100).
	always_comb begin
		val     = {sample, 8'd0};
		avg_sum = AVG_SUM_W'(average_q) * AVG_KEEP + AVG_SUM_W'(val);
		quarter = avg_sum[AVG_SUM_W-1:2];
		prod    = 43'(quarter) * 43'(RECIP_25);
		avg     = prod[RECIP_SH+15:RECIP_SH];
	end

	// Distance from the average and level by compares against multiples of the threshold.
	always_comb begin
		diff   = (avg > val) ? (avg - val) : (val - avg);
		motion = diff > motion_threshold;
		thr2   = {motion_threshold, 1'b0};
		thr3   = 18'(motion_threshold) + 18'(thr2);
		if (!motion) begin
			level = 2'd0;
		end else if (18'(diff) >= thr3) begin
			level = 2'd3;
		end else if (17'(diff) >= thr2) begin
			level = 2'd2;
		end else begin
			level = 2'd1;
		end
	end

	// The average snaps to the sample on motion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			average_q <= 16'd0;
		end else if (upd) begin
			average_q <= motion ? val : avg;
		end
	end

endmodule

FILE: src/mtlc_burst.sv
// Running clock, burst control and LED rotation.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mtlc_burst #(
	parameter int LED_COUNT       = mtlc_pkg::LED_COUNT_DEF,
	parameter int BURST_PER_LEVEL = mtlc_pkg::BURST_PER_LEVEL_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  logic [1:0]        level,
	input  logic [15:0]       tick_period,
	input  logic [15:0]       idle_holdoff,
	output mtlc_pkg::result_t res
);
	import mtlc_pkg::*;

	localparam int LedW   = $clog2(LED_COUNT);
	localparam int BurstW = $clog2(3 * BURST_PER_LEVEL + 1);
	localparam logic [LedW-1:0]   LedLast  = LedW'(LED_COUNT - 1);
	localparam logic [BurstW-1:0] Burst1   = BurstW'(BURST_PER_LEVEL);
	localparam logic [BurstW-1:0] Burst2   = BurstW'(2 * BURST_PER_LEVEL);
	localparam logic [BurstW-1:0] Burst3   = BurstW'(3 * BURST_PER_LEVEL);

	logic [31:0]       clock_q;
	logic [15:0]       idle_q;
	logic [BurstW-1:0] burst_q;
	logic [LedW-1:0]   led_q;

	logic [31:0]       clock_nxt;
	logic [15:0]       idle_nxt;
	logic [BurstW-1:0] burst_nxt;
	logic [LedW-1:0]   led_nxt;
	logic [BurstW-1:0] burst_len;
	logic [BurstW-1:0] burst_cur;
	logic              start;
	logic [7:0]        led_ext;

	// Burst length for the detected level.
	always_comb begin
		case (level)
			2'd1:    burst_len = Burst1;
			2'd2:    burst_len = Burst2;
			2'd3:    burst_len = Burst3;
			default: burst_len = '0;
		endcase
	end

	// Clock advance, retrigger test and one step of the burst.
	always_comb begin
		clock_nxt = clock_q + 32'(tick_period);
		start     = (burst_q == '0) && (level != 2'd0) &&
			(clock_nxt > (32'(idle_q) + 32'(idle_holdoff)));
		burst_cur = start ? burst_len : burst_q;
		burst_nxt = burst_cur;
		led_nxt   = led_q;
		idle_nxt  = idle_q;
		led_ext   = 8'(led_q);
		res.motion_level = level;
		res.pulse_valid  = 1'b0;
		res.pulse_led    = 2'd0;
		res.wake_request = start ? WAKE_FAST : WAKE_KEEP;
		if (burst_cur != '0) begin
			burst_nxt       = burst_cur - 1'b1;
			res.pulse_valid = 1'b1;
			res.pulse_led   = led_ext[1:0];
			led_nxt         = (led_q == LedLast) ? '0 : led_q + 1'b1;
			if (burst_nxt == '0) begin
				idle_nxt         = clock_nxt[15:0];
				res.wake_request = WAKE_SLOW;
			end
		end
	end

	// State advances once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= 32'd0;
			idle_q  <= 16'd0;
			burst_q <= '0;
			led_q   <= '0;
		end else if (upd) begin
			clock_q <= clock_nxt;
			idle_q  <= idle_nxt;
			burst_q <= burst_nxt;
			led_q   <= led_nxt;
		end
	end

	// The rotation and the burst counter stay in range; wake codes match the burst state.
	`MTLC_ASSERT(a_led_range, led_q <= LedLast, "LED index out of range")
	`MTLC_ASSERT(a_burst_range, burst_q <= Burst3, "burst counter above the longest burst")
	`MTLC_ASSERT(a_fast_from_idle, (upd && res.wake_request == WAKE_FAST) |-> (burst_q == '0 && res.pulse_valid), "fast wake without an idle start")
	`MTLC_ASSERT_NEXT(a_slow_ends, upd && res.wake_request == WAKE_SLOW, burst_q == '0, "slow wake while a burst continues")

endmodule

FILE: src/motion_triggered_led_chase_top.sv
// Top level of the motion-triggered LED chase: handshakes, configuration and pipeline.
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  tick     | tick_valid, tick_ready, tick (tick_t)     | in
//  result   | result_valid, result_ready, result        | out
//  config   | cfg_we, cfg_index, cfg_data               | in
//
// Three register stages: input, detection, result. An accepted transaction moves on
// to detection and result; one transaction per cycle is sustained while result_ready
// is high. The combinational average update (multiply by 99, divide by 100) sets the
// clock period. Reset clears valid and control state and loads the register defaults.
// A stalled result holds only the stages behind it; empty stages still fill.
`timescale 1ns / 1ps
module motion_triggered_led_chase_top #(
	parameter int LED_COUNT       = mtlc_pkg::LED_COUNT_DEF,
	parameter int BURST_PER_LEVEL = mtlc_pkg::BURST_PER_LEVEL_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               tick_valid,
	output logic                               tick_ready,
	input  mtlc_pkg::tick_t                    tick,
	output logic                               result_valid,
	input  logic                               result_ready,
	output mtlc_pkg::result_t                  result,
	input  logic                               cfg_we,
	input  logic [mtlc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mtlc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mtlc_pkg::*;

	logic [15:0] threshold_q;
	logic [15:0] holdoff_q;

	logic        v_s1;
	logic        v_s2;
	logic        v_s3;
	tick_t       tick_s1;
	logic [1:0]  level_s2;
	logic [15:0] period_s2;
	result_t     result_s3;

	logic        en1;
	logic        en2;
	logic        en3;
	logic [1:0]  level;
	result_t     res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			holdoff_q   <= HOLDOFF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data;
				CFG_HOLDOFF:   holdoff_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A stage advances when it is empty or the stage after it advances.
	assign en3          = !v_s3 || result_ready;
	assign en2          = !v_s2 || en3;
	assign en1          = !v_s1 || en2;
	assign tick_ready   = en1;
	assign result_valid = v_s3;
	assign result       = result_s3;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= tick_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (en1 && tick_valid) begin
			tick_s1 <= tick;
		end
		if (en2 && v_s1) begin
			level_s2  <= level;
			period_s2 <= tick_s1.tick_period;
		end
		if (en3 && v_s2) begin
			result_s3 <= res;
		end
	end

	// Average update and motion level.
	mtlc_detect u_detect (
		.clk              (clk),
		.arst_n           (arst_n),
		.upd              (en2 && v_s1),
		.sample           (tick_s1.sample),
		.motion_threshold (threshold_q),
		.level            (level)
	);

	// Burst control and LED rotation.
	mtlc_burst #(
		.LED_COUNT       (LED_COUNT),
		.BURST_PER_LEVEL (BURST_PER_LEVEL)
	) u_burst (
		.clk          (clk),
		.arst_n       (arst_n),
		.upd          (en3 && v_s2),
		.level        (level_s2),
		.tick_period  (period_s2),
		.idle_holdoff (holdoff_q),
		.res          (res)
	);

endmodule
